@@ src/rsmf_pkg.sv @@
`timescale 1ns / 1ps
package rsmf_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;

	localparam int PIX_W  = 8;
	localparam int COL_W  = $clog2(MAX_WIDTH);       // column index into a line store
	localparam int WID_W  = 11;                      // image_width register
	localparam int HGT_W  = 13;                      // image_height register
	localparam int ROW_W  = HGT_W;                   // input row runs up to height + 1
	localparam int CFG_W  = HGT_W;                   // widest register
	localparam int IDX_W  = 2;
	localparam int SUM_W  = 12;                      // 16 * 255 fits

	localparam logic [IDX_W-1:0] CFG_MODE   = 2'd0;
	localparam logic [IDX_W-1:0] CFG_WIDTH  = 2'd1;
	localparam logic [IDX_W-1:0] CFG_HEIGHT = 2'd2;

	localparam logic [WID_W-1:0] WIDTH_RESET  = 11'd640;
	localparam logic [HGT_W-1:0] HEIGHT_RESET = 13'd480;
	localparam logic [WID_W-1:0] WIDTH_MIN    = 11'd3;
	localparam logic [WID_W-1:0] WIDTH_MAX    = WID_W'(MAX_WIDTH);
	localparam logic [HGT_W-1:0] HEIGHT_MIN   = 13'd3;
	localparam logic [HGT_W-1:0] HEIGHT_MAX   = HGT_W'(MAX_HEIGHT);

	// floor(s / 9) == (s * 3641) >> 15 for every s below 32768
	localparam logic [SUM_W-1:0] BOX_RECIP = 12'd3641;
	localparam int               BOX_SHIFT = 15;

	// 1-2-1 kernel weights as left shifts, row-major
	localparam logic [1:0] GAUSS_SHIFT [9] = '{2'd0, 2'd1, 2'd0,
	                                           2'd1, 2'd2, 2'd1,
	                                           2'd0, 2'd1, 2'd0};

	typedef enum logic [1:0] {
		MODE_GAUSS  = 2'd0,
		MODE_BOX    = 2'd1,
		MODE_MEDIAN = 2'd2,
		MODE_PASS   = 2'd3
	} mode_t;

	typedef logic [PIX_W-1:0] pixel_t;
	typedef pixel_t [8:0]     window_t;

endpackage

@@ src/rsmf_window_filter.sv @@
`timescale 1ns / 1ps
module rsmf_window_filter (
	input  rsmf_pkg::window_t win,
	input  rsmf_pkg::mode_t   mode,
	input  logic              border,
	output rsmf_pkg::pixel_t  pixel
);

	logic [rsmf_pkg::SUM_W-1:0]     gauss_sum;
	logic [rsmf_pkg::SUM_W-1:0]     box_sum;
	logic [2*rsmf_pkg::SUM_W-1:0]   box_prod;
	logic [3:0]                     rank [9];
	rsmf_pkg::pixel_t               median;
	rsmf_pkg::pixel_t               filtered;

	// kernel and box sums
	always_comb begin
		gauss_sum = '0;
		box_sum   = '0;
		for (int k = 0; k < 9; k++) begin
			gauss_sum = gauss_sum
			          + (rsmf_pkg::SUM_W'(win[k]) << rsmf_pkg::GAUSS_SHIFT[k]);
			box_sum   = box_sum + rsmf_pkg::SUM_W'(win[k]);
		end
	end

	assign box_prod = box_sum * rsmf_pkg::BOX_RECIP;

	// median by rank: ties broken by position, so ranks form a permutation
	always_comb begin
		for (int i = 0; i < 9; i++) begin
			rank[i] = '0;
			for (int j = 0; j < 9; j++) begin
				if (j != i) begin
					if ((win[j] < win[i]) || ((win[j] == win[i]) && (j < i))) begin
						rank[i] = rank[i] + 4'd1;
					end
				end
			end
		end
		median = '0;
		for (int i = 0; i < 9; i++) begin
			if (rank[i] == 4'd4) begin
				median = median | win[i];
			end
		end
	end

	always_comb begin
		unique case (mode)
			rsmf_pkg::MODE_GAUSS:  filtered = gauss_sum[rsmf_pkg::SUM_W-1:4];
			rsmf_pkg::MODE_BOX:    filtered = box_prod[rsmf_pkg::BOX_SHIFT +: rsmf_pkg::PIX_W];
			rsmf_pkg::MODE_MEDIAN: filtered = median;
			rsmf_pkg::MODE_PASS:   filtered = win[4];
		endcase
	end

	assign pixel = border ? win[4] : filtered;

endmodule

@@ src/raster_3x3_smooth_median_filter.sv @@
`timescale 1ns / 1ps
// The pixel transaction completing a window goes through the line store read, the window
// shift and the filter to the output register. Throughput: one pixel per cycle while no
// stalled result holds the pipe, set by the single read and write port of each line store.
// Reset (arst_n low, asynchronous): position counters, window and valid flags clear,
// registers return to Gaussian mode, 640 x 480. Line stores are not cleared; border
// outputs never use their unwritten entries.
module raster_3x3_smooth_median_filter (
	input  logic                            clk,
	input  logic                            arst_n,
	// pixel channel
	input  logic                            pixel_valid,
	output logic                            pixel_stall,
	input  logic [rsmf_pkg::PIX_W-1:0]      pixel_in,
	input  logic                            filler,
	// result channel
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic [rsmf_pkg::PIX_W-1:0]      pixel_out,
	output logic                            last_pixel,
	// configuration
	input  logic                            cfg_write,
	input  logic [rsmf_pkg::IDX_W-1:0]      cfg_index,
	input  logic [rsmf_pkg::CFG_W-1:0]      cfg_data
);

	// ---------------------------------------------------------------------------------
	// Configuration registers and clamped sizes
	// ---------------------------------------------------------------------------------
	rsmf_pkg::mode_t                mode_q;
	logic [rsmf_pkg::WID_W-1:0]     width_q;
	logic [rsmf_pkg::HGT_W-1:0]     height_q;
	logic [rsmf_pkg::WID_W-1:0]     width_eff;
	logic [rsmf_pkg::HGT_W-1:0]     height_eff;
	logic [rsmf_pkg::WID_W-1:0]     width_m1;
	logic                           size_write;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= rsmf_pkg::MODE_GAUSS;
			width_q  <= rsmf_pkg::WIDTH_RESET;
			height_q <= rsmf_pkg::HEIGHT_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				rsmf_pkg::CFG_MODE:   mode_q   <= rsmf_pkg::mode_t'(cfg_data[1:0]);
				rsmf_pkg::CFG_WIDTH:  width_q  <= cfg_data[rsmf_pkg::WID_W-1:0];
				rsmf_pkg::CFG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// a size write starts a new image
	assign size_write = cfg_write
	                  && ((cfg_index == rsmf_pkg::CFG_WIDTH) || (cfg_index == rsmf_pkg::CFG_HEIGHT));

	always_comb begin
		priority if (width_q < rsmf_pkg::WIDTH_MIN) width_eff = rsmf_pkg::WIDTH_MIN;
		else if (width_q > rsmf_pkg::WIDTH_MAX)     width_eff = rsmf_pkg::WIDTH_MAX;
		else                                        width_eff = width_q;
		priority if (height_q < rsmf_pkg::HEIGHT_MIN) height_eff = rsmf_pkg::HEIGHT_MIN;
		else if (height_q > rsmf_pkg::HEIGHT_MAX)     height_eff = rsmf_pkg::HEIGHT_MAX;
		else                                          height_eff = height_q;
	end

	assign width_m1 = width_eff - rsmf_pkg::WID_W'(1);

	// ---------------------------------------------------------------------------------
	// Flow control: one shared enable; the pipe moves unless a finished result is stuck
	// ---------------------------------------------------------------------------------
	logic adv;
	assign adv         = !result_valid || !result_stall;
	assign pixel_stall = !adv;

	// ---------------------------------------------------------------------------------
	// Input stage: position counters. Output position trails input by width + 1, so the
	// border and end-of-image flags are worked out here from the input position.
	// ---------------------------------------------------------------------------------
	logic [rsmf_pkg::COL_W-1:0]     in_column_q;
	logic [rsmf_pkg::ROW_W-1:0]     in_row_q;
	logic [rsmf_pkg::COL_W-1:0]     col;
	logic                           padding;
	logic                           take;
	rsmf_pkg::pixel_t               px;
	logic                           emit;
	logic                           border;
	logic                           last;
	logic                           col_wrap;
	logic [rsmf_pkg::ROW_W:0]       height_p1;

	assign col       = ({1'b0, in_column_q} >= width_eff) ? width_m1[rsmf_pkg::COL_W-1:0]
	                                                       : in_column_q;
	assign padding   = in_row_q >= height_eff;
	// filler inside the image is swallowed; once padding, every transaction counts
	assign take      = pixel_valid && adv && (padding || !filler);
	assign px        = padding ? '0 : pixel_in;
	assign emit      = (in_row_q >= rsmf_pkg::ROW_W'(2))
	                 || ((in_row_q == rsmf_pkg::ROW_W'(1)) && (col != '0));
	// left and right columns land on columns 1 and 0 of the input; top and bottom rows
	// on input rows 1 and height onwards
	assign border    = (col == rsmf_pkg::COL_W'(0)) || (col == rsmf_pkg::COL_W'(1))
	                 || (in_row_q == rsmf_pkg::ROW_W'(1)) || (in_row_q >= height_eff);
	assign height_p1 = {1'b0, height_eff} + (rsmf_pkg::ROW_W+1)'(1);
	assign last      = (col == '0) && ({1'b0, in_row_q} >= height_p1);
	assign col_wrap  = ({1'b0, col} + rsmf_pkg::WID_W'(1)) >= width_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_column_q <= '0;
			in_row_q    <= '0;
		end else if (size_write) begin
			in_column_q <= '0;
			in_row_q    <= '0;
		end else if (take) begin
			if (emit && last) begin
				in_column_q <= '0;
				in_row_q    <= '0;
			end else if (col_wrap) begin
				in_column_q <= '0;
				if (in_row_q <= height_eff) begin
					in_row_q <= in_row_q + rsmf_pkg::ROW_W'(1);
				end
			end else begin
				in_column_q <= col + rsmf_pkg::COL_W'(1);
			end
		end
	end

	// ---------------------------------------------------------------------------------
	// Stage 1: line store read registered, pixel and flags travel alongside
	// ---------------------------------------------------------------------------------
	rsmf_pkg::pixel_t               line_upper  [rsmf_pkg::MAX_WIDTH];
	rsmf_pkg::pixel_t               line_middle [rsmf_pkg::MAX_WIDTH];
	rsmf_pkg::pixel_t               rd_up_s1;
	rsmf_pkg::pixel_t               rd_mid_s1;
	logic                           valid_s1;
	rsmf_pkg::pixel_t               px_s1;
	logic [rsmf_pkg::COL_W-1:0]     col_s1;
	logic                           emit_s1;
	logic                           border_s1;
	logic                           last_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			rd_up_s1  <= line_upper[col];
			rd_mid_s1 <= line_middle[col];
		end
	end

	// in an image, item n's write and item n+1's read hit different columns (width >= 3)
	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			line_upper[col_s1]  <= rd_mid_s1;
			line_middle[col_s1] <= px_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s1     <= px;
			col_s1    <= col;
			emit_s1   <= emit;
			border_s1 <= border;
			last_s1   <= last;
		end
	end

	// ---------------------------------------------------------------------------------
	// Stage 2: 3x3 window shifted in, filter computed from it
	// ---------------------------------------------------------------------------------
	rsmf_pkg::window_t              win_q;
	logic                           valid_s2;
	logic                           border_s2;
	logic                           last_s2;
	rsmf_pkg::pixel_t               filt_pixel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (adv && valid_s1) begin
			win_q[0] <= win_q[1];
			win_q[1] <= win_q[2];
			win_q[2] <= rd_up_s1;
			win_q[3] <= win_q[4];
			win_q[4] <= win_q[5];
			win_q[5] <= rd_mid_s1;
			win_q[6] <= win_q[7];
			win_q[7] <= win_q[8];
			win_q[8] <= px_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1 && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			border_s2 <= border_s1;
			last_s2   <= last_s1;
		end
	end

	rsmf_window_filter u_filter (
		.win    (win_q),
		.mode   (mode_q),
		.border (border_s2),
		.pixel  (filt_pixel)
	);

	// ---------------------------------------------------------------------------------
	// Output register: holds a result until its transaction completes
	// ---------------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (adv) begin
			result_valid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s2) begin
			pixel_out  <= filt_pixel;
			last_pixel <= last_s2;
		end
	end

	// ---------------------------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------------------------
	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, in_column_q} < width_eff)
		else $error("input column beyond image width");

	a_row_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, in_row_q} <= height_p1)
		else $error("input row beyond padding limit");

	a_last_is_border: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && last_s2 |-> border_s2)
		else $error("final pixel not flagged as border");

	a_result_from_s2: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(valid_s2))
		else $error("result appeared without a filtered window");

endmodule

@@ verif/raster_3x3_smooth_median_filter_tb.sv @@
`timescale 1ns / 1ps
module raster_3x3_smooth_median_filter_tb;

	localparam int unsigned SETTLE_CYCLES = 8;     // comfortably past the pipeline latency
	localparam int unsigned QUIET_LIMIT   = 1000;  // cycles with no transaction on either side
	localparam int unsigned HOLD_CYCLES   = 200;   // long receiver hold-off
	localparam int unsigned IDLE_PCT      = 16;
	localparam int unsigned RANDOM_ITEMS  = 500;

	typedef struct packed {
		rsmf_pkg::pixel_t value;
		logic             last;
	} out_pixel_t;

	// pixel content of a random frame
	typedef enum int unsigned {
		FILL_RANDOM,
		FILL_EXTREME,
		FILL_NEAR,
		FILL_FLAT
	} texture_t;

	// Tracks the filter state and holds the output pixels still to arrive.
	class smooth_scoreboard;
		rsmf_pkg::pixel_t           upper_line [rsmf_pkg::MAX_WIDTH];
		rsmf_pkg::pixel_t           middle_line [rsmf_pkg::MAX_WIDTH];
		rsmf_pkg::pixel_t           win [9];
		int unsigned                in_col, in_row, out_col, out_row;
		rsmf_pkg::mode_t            mode;
		logic [rsmf_pkg::WID_W-1:0] width_reg;
		logic [rsmf_pkg::HGT_W-1:0] height_reg;
		out_pixel_t                 awaited [$];
		int unsigned                errors;

		function new();
			foreach (upper_line[i]) begin
				upper_line[i]  = '0;
				middle_line[i] = '0;
			end
			foreach (win[i]) win[i] = '0;
			restart();
			mode       = rsmf_pkg::MODE_GAUSS;
			width_reg  = rsmf_pkg::WIDTH_RESET;
			height_reg = rsmf_pkg::HEIGHT_RESET;
			errors     = 0;
		endfunction

		function void restart();
			in_col  = 0;
			in_row  = 0;
			out_col = 0;
			out_row = 0;
		endfunction

		function int unsigned eff_width();
			if (width_reg < rsmf_pkg::WIDTH_MIN) return rsmf_pkg::WIDTH_MIN;
			if (width_reg > rsmf_pkg::WIDTH_MAX) return rsmf_pkg::WIDTH_MAX;
			return width_reg;
		endfunction

		function int unsigned eff_height();
			if (height_reg < rsmf_pkg::HEIGHT_MIN) return rsmf_pkg::HEIGHT_MIN;
			if (height_reg > rsmf_pkg::HEIGHT_MAX) return rsmf_pkg::HEIGHT_MAX;
			return height_reg;
		endfunction

		function bit idle();
			return awaited.size() == 0;
		endfunction

		// size writes start a new image; a mode write only swaps the filter
		function void write_reg(input logic [rsmf_pkg::IDX_W-1:0] idx,
				input logic [rsmf_pkg::CFG_W-1:0] data);
			case (idx)
				rsmf_pkg::CFG_MODE: mode = rsmf_pkg::mode_t'(data[1:0]);
				rsmf_pkg::CFG_WIDTH: begin
					width_reg = data[rsmf_pkg::WID_W-1:0];
					restart();
				end
				rsmf_pkg::CFG_HEIGHT: begin
					height_reg = data[rsmf_pkg::HGT_W-1:0];
					restart();
				end
				default: ;
			endcase
		endfunction

		function rsmf_pkg::pixel_t smooth();
			int unsigned      acc;
			rsmf_pkg::pixel_t sorted [9];
			rsmf_pkg::pixel_t t;
			int               i, j;
			case (mode)
				rsmf_pkg::MODE_GAUSS: begin
					acc = win[0] + win[2] + win[6] + win[8]
						+ 2 * (win[1] + win[3] + win[5] + win[7]) + 4 * win[4];
					return rsmf_pkg::pixel_t'(acc / 16);
				end
				rsmf_pkg::MODE_BOX: begin
					acc = 0;
					for (i = 0; i < 9; i++) acc += win[i];
					return rsmf_pkg::pixel_t'(acc / 9);
				end
				rsmf_pkg::MODE_MEDIAN: begin
					sorted = win;
					for (i = 0; i < 8; i++)
						for (j = 0; j < 8 - i; j++)
							if (sorted[j] > sorted[j + 1]) begin
								t             = sorted[j];
								sorted[j]     = sorted[j + 1];
								sorted[j + 1] = t;
							end
					return sorted[4];
				end
				default: return win[4];
			endcase
		endfunction

		function void note_pixel(input rsmf_pkg::pixel_t px, input logic fill);
			int unsigned      w, h, col, k;
			rsmf_pkg::pixel_t fresh, up, mid;
			bit               emit, border;
			out_pixel_t       res;
			w   = eff_width();
			h   = eff_height();
			col = in_col;
			// filler inside the image is dropped; past the image everything is padding
			if (in_row < h && fill) return;
			fresh = (in_row >= h) ? rsmf_pkg::pixel_t'(0) : px;
			if (col >= w) col = w - 1;
			up  = upper_line[col];
			mid = middle_line[col];
			for (k = 0; k < 9; k += 3) begin
				win[k]     = win[k + 1];
				win[k + 1] = win[k + 2];
			end
			win[2] = up;
			win[5] = mid;
			win[8] = fresh;
			upper_line[col]  = mid;
			middle_line[col] = fresh;
			emit = in_row >= 2 || (in_row == 1 && col >= 1);
			if (col + 1 >= w) begin
				in_col = 0;
				if (in_row <= h) in_row++;
			end else
				in_col = col + 1;
			if (!emit) return;
			border    = out_row == 0 || out_row >= h - 1 || out_col == 0 || out_col >= w - 1;
			res.value = border ? win[4] : smooth();
			res.last  = out_row >= h - 1 && out_col >= w - 1;
			awaited.push_back(res);
			if (res.last)
				restart();
			else if (out_col + 1 >= w) begin
				out_col = 0;
				out_row++;
			end else
				out_col++;
		endfunction

		function void check_result(input rsmf_pkg::pixel_t px, input logic last);
			out_pixel_t due;
			if (awaited.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, pixel_out %0d last_pixel %0b", $time, px, last);
				return;
			end
			due = awaited.pop_front();
			if (px !== due.value) begin
				errors++;
				$display("%0t: pixel_out expected %0d, got %0d", $time, due.value, px);
			end
			if (last !== due.last) begin
				errors++;
				$display("%0t: last_pixel expected %0b, got %0b", $time, due.last, last);
			end
		endfunction
	endclass

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           pixel_valid = 1'b0;
	logic                           pixel_stall;
	rsmf_pkg::pixel_t               pixel_in = '0;
	logic                           filler = 1'b0;
	logic                           result_valid;
	logic                           result_stall = 1'b0;
	rsmf_pkg::pixel_t               pixel_out;
	logic                           last_pixel;
	logic                           cfg_write = 1'b0;
	logic [rsmf_pkg::IDX_W-1:0]     cfg_index = rsmf_pkg::CFG_MODE;
	logic [rsmf_pkg::CFG_W-1:0]     cfg_data = '0;

	smooth_scoreboard   sb;
	bit                 idle_on = 1'b1;      // random gaps on both sides
	int unsigned        hold_request = 0;    // receiver hold-off asked for by the stimulus
	int unsigned        quiet = 0;

	raster_3x3_smooth_median_filter dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.pixel_in     (pixel_in),
		.filler       (filler),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.pixel_out    (pixel_out),
		.last_pixel   (last_pixel),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Both channels are sampled at the rising edge. Every transaction goes to
	// the scoreboard. The watchdog ends the run if neither side moves for too long.
	always @(posedge clk) begin : monitor
		bit took_in, took_out;
		took_in  = arst_n && pixel_valid && !pixel_stall;
		took_out = arst_n && result_valid && !result_stall;
		if (took_in) sb.note_pixel(pixel_in, filler);
		if (took_out) sb.check_result(pixel_out, last_pixel);
		if (took_in || took_out || !arst_n)
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("raster_3x3_smooth_median_filter_tb: done, errors");
			$finish;
		end
	end

	// Result side: random stall, or a long counted hold-off on request so the
	// filter backs up and stalls its pixel input.
	initial begin : result_side
		int unsigned hold_left;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_request != 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left != 0) begin
				result_stall <= 1'b1;
				hold_left--;
			end else
				result_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
		end
	end

	// One pixel transaction. Called and returns on a falling edge; valid stays
	// high afterwards unless the next call idles first.
	task automatic send_pixel(input rsmf_pkg::pixel_t px, input logic fill);
		while (idle_on && $urandom_range(99) < IDLE_PCT) begin
			pixel_valid <= 1'b0;
			@(negedge clk);
		end
		pixel_valid <= 1'b1;
		pixel_in    <= px;
		filler      <= fill;
		do begin
			@(posedge clk);
		end while (pixel_stall !== 1'b0);
		@(negedge clk);
	endtask

	// Drain: every queued pixel back, then a few cycles for items still in flight
	// that produce no output.
	task automatic settle();
		pixel_valid <= 1'b0;
		while (!sb.idle()) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [rsmf_pkg::IDX_W-1:0] idx,
			input logic [rsmf_pkg::CFG_W-1:0] data);
		settle();
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_write <= 1'b0;
		sb.write_reg(idx, data);
	endtask

	function automatic rsmf_pkg::pixel_t pick_pixel(input texture_t texture,
			input rsmf_pkg::pixel_t base);
		int v;
		case (texture)
			FILL_EXTREME: v = $urandom_range(0, 1) ? 255 : 0;
			FILL_NEAR: begin
				v = int'(base) + int'($urandom_range(0, 32)) - 16;
				if (v < 0) v = 0;
				if (v > 255) v = 255;
			end
			FILL_FLAT: v = base;
			default: v = $urandom_range(0, 255);
		endcase
		return rsmf_pkg::pixel_t'(v);
	endfunction

	// A frame of w x h pixels. A short cut leaves the image unfinished. A full
	// frame gets w+1 padding items, the odd one carrying a pixel, then maybe a
	// stray filler or two that the next image ignores.
	task automatic send_frame(input int unsigned w, input int unsigned h,
			input texture_t texture, input int unsigned cut, output int unsigned n);
		int unsigned      k;
		rsmf_pkg::pixel_t base;
		base = rsmf_pkg::pixel_t'($urandom_range(0, 255));
		n    = 0;
		for (k = 0; k < cut; k++) begin
			if ($urandom_range(99) < 5)
				send_pixel(rsmf_pkg::pixel_t'($urandom_range(0, 255)), 1'b1);
			send_pixel(pick_pixel(texture, base), 1'b0);
			n++;
		end
		if (cut == w * h) begin
			for (k = 0; k <= w; k++) begin
				send_pixel(rsmf_pkg::pixel_t'($urandom_range(0, 255)), $urandom_range(99) >= 10);
				n++;
			end
			repeat ($urandom_range(0, 2))
				send_pixel(rsmf_pkg::pixel_t'($urandom_range(0, 255)), 1'b1);
		end
	endtask

	initial begin : stimulus
		int unsigned                frame, w, h, cut, n, k, small_items;
		logic [rsmf_pkg::CFG_W-1:0] wv, hv, mv;
		bit                         need_size, big;
		sb = new();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: pass-through mode with junk above the mode bits, and sizes
		// below the minimum (both clamp to 3).
		write_reg(rsmf_pkg::CFG_MODE, {11'h555, rsmf_pkg::MODE_PASS});
		write_reg(rsmf_pkg::CFG_WIDTH, 13'd2);
		write_reg(rsmf_pkg::CFG_HEIGHT, 13'd1);
		// 3x3 of 0/255 with a filler dropped in mid-image
		for (k = 0; k < 9; k++) begin
			if (k == 4) send_pixel(8'hFF, 1'b1);
			send_pixel(k[0] ? 8'hFF : 8'h00, 1'b0);
		end
		// padding, one item carrying a pixel that must read as zero
		send_pixel(8'h00, 1'b1);
		send_pixel(8'hA5, 1'b0);
		send_pixel(8'h00, 1'b1);
		send_pixel(8'hFF, 1'b1);
		// next image starts straight away, then is cut short by a size write
		send_pixel(8'hFF, 1'b0);
		send_pixel(8'h01, 1'b0);
		send_pixel(8'hFE, 1'b0);

		// Random frames. Frame 1 runs under the long hold-off; frame 3 is the
		// widest image and frame 6 the tallest, both reached by clamping all-ones
		// writes and cut short once the clamped size shows in the results.
		// Frames 4 to 7 run with no idling at all.
		need_size   = 1'b1;
		small_items = 0;
		frame       = 0;
		while (small_items < RANDOM_ITEMS) begin
			if (frame == 4) idle_on = 1'b0;
			if (frame == 8) idle_on = 1'b1;
			if (frame == 0 || $urandom_range(99) < 50) begin
				mv      = rsmf_pkg::CFG_W'($urandom());
				mv[1:0] = (frame == 0) ? rsmf_pkg::MODE_GAUSS : 2'($urandom_range(0, 3));
				write_reg(rsmf_pkg::CFG_MODE, mv);
			end
			big = frame == 3 || frame == 6;
			if (frame == 3) begin
				wv = '1;
				hv = 13'd3;
			end else if (frame == 6) begin
				wv = 13'd3;
				hv = '1;
			end else if (frame == 1) begin
				wv = 13'd12;
				hv = 13'd8;
			end else begin
				wv = ($urandom_range(99) < 10) ? rsmf_pkg::CFG_W'($urandom_range(0, 2))
					: rsmf_pkg::CFG_W'($urandom_range(3, 12));
				if ($urandom_range(99) < 25) wv[12:11] = 2'($urandom_range(0, 3));
				hv = ($urandom_range(99) < 10) ? rsmf_pkg::CFG_W'($urandom_range(0, 2))
					: rsmf_pkg::CFG_W'($urandom_range(3, 8));
			end
			if (need_size || big || frame == 1 || $urandom_range(99) < 60) begin
				write_reg(rsmf_pkg::CFG_WIDTH, wv);
				write_reg(rsmf_pkg::CFG_HEIGHT, hv);
			end
			w   = sb.eff_width();
			h   = sb.eff_height();
			cut = w * h;
			// wide: one row and a few pixels, enough to see the column wrap at the limit;
			// tall: twenty full rows of pixels
			if (frame == 3)
				cut = w + 4;
			else if (frame == 6)
				cut = 20 * w;
			else if (frame != 1 && $urandom_range(99) < 10)
				cut = $urandom_range(1, w * h - 1);
			need_size = big || cut != w * h;
			if (frame == 1) hold_request = HOLD_CYCLES;
			send_frame(w, h, texture_t'($urandom_range(0, 3)), cut, n);
			if (!big) small_items += n;
			frame++;
		end

		settle();
		if (sb.errors == 0)
			$display("raster_3x3_smooth_median_filter_tb: done, clean");
		else
			$display("raster_3x3_smooth_median_filter_tb: done, errors");
		$finish;
	end

endmodule

@@ sim.f @@
src/rsmf_pkg.sv
src/rsmf_window_filter.sv
src/raster_3x3_smooth_median_filter.sv
verif/raster_3x3_smooth_median_filter_tb.sv
